// File: hdl/bns_pkg.sv
// bitmap nearest-set search: shared types and constants
// no dependencies; imported by the scanner, the top level, the checker and the testbench
package bns_pkg;

	localparam int MAX_OFF_W     = 6;

	// action codes of a request
	localparam logic [1:0] ACT_QUERY = 2'd0;
	localparam logic [1:0] ACT_SET   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// control of one word scan
	typedef struct packed {
		logic                 up;       // search toward higher bits
		logic                 at_home;  // word holds the request position
		logic [MAX_OFF_W-1:0] off;      // bit offset of the request position
		logic                 lim_en;   // word holds the last active position
		logic [MAX_OFF_W-1:0] lim;      // offset of the last active position
	} scan_ctrl_t;

endpackage

// File: hdl/bns_req_if.sv
// request channel: action and position with valid/ready handshake
// no dependencies
interface bns_req_if #(parameter int POS_W = 10);
	logic             valid;
	logic             ready;
	logic [1:0]       action;
	logic [POS_W-1:0] position;

	modport source (output valid, output action, output position, input ready);
	modport sink   (input valid, input action, input position, output ready);
endinterface

// File: hdl/bns_rsp_if.sv
// response channel: search results with valid/ready handshake
// no dependencies
interface bns_rsp_if #(parameter int POS_W = 10);
	logic             valid;
	logic             ready;
	logic             bit_is_set;
	logic             left_found;
	logic [POS_W-1:0] left_position;
	logic             right_hit;
	logic [POS_W-1:0] right_position;
	logic             out_of_range;

	modport source (output valid, output bit_is_set, output left_found,
		output left_position, output right_hit, output right_position,
		output out_of_range, input ready);
	modport sink   (input valid, input bit_is_set, input left_found,
		input left_position, input right_hit, input right_position,
		input out_of_range, output ready);
endinterface

// File: hdl/bns_mem.sv
// bitmap word store: one write port, one read port, registered read data
// no dependencies
module bns_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/bns_word_scan.sv
// nearest set bit within one bitmap word, upward or downward
// depends on bns_pkg (scan_ctrl_t)
module bns_word_scan #(
	parameter int WORD_BITS = 64,
	localparam int OFF_W    = $clog2(WORD_BITS)
) (
	input  logic [WORD_BITS-1:0] word,
	input  bns_pkg::scan_ctrl_t  ctrl,
	output logic                 found,
	output logic [OFF_W-1:0]     idx
);
	import bns_pkg::*;

	logic [OFF_W-1:0]     off;
	logic [OFF_W-1:0]     lim;
	logic [WORD_BITS-1:0] cand;
	logic [WORD_BITS-1:0] ordered;
	logic [WORD_BITS-1:0] lowest;
	logic [OFF_W-1:0]     k;

	assign off = ctrl.off[OFF_W-1:0];
	assign lim = ctrl.lim[OFF_W-1:0];

	// candidate bits, put in search order so the lowest set bit is the answer
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			cand[b] = word[b]
				& (!ctrl.at_home || (ctrl.up ? (OFF_W'(b) > off) : (OFF_W'(b) < off)))
				& (!ctrl.up || !ctrl.lim_en || (OFF_W'(b) <= lim));
		end
		for (int b = 0; b < WORD_BITS; b++) begin
			ordered[b] = ctrl.up ? cand[b] : cand[WORD_BITS-1-b];
		end
	end

	assign lowest = ordered & (~ordered + WORD_BITS'(1));

	always_comb begin
		k = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (lowest[b]) begin
				k = k | OFF_W'(b);
			end
		end
	end

	assign found = |ordered;
	assign idx   = ctrl.up ? k : (OFF_W'(WORD_BITS - 1) - k);

endmodule

// File: hdl/bitmap_nearest_set_search.sv
// bitmap nearest-set search, top level
// depends on bns_pkg, bns_req_if, bns_rsp_if, bns_mem, bns_word_scan
// usage:
//   req carries one request: an action (query, set, clear) and a position.
//   rsp carries one response per request: the bit after the update, the
//   nearest set position below and the nearest set position above (below
//   the active size), each with a found flag, and an out-of-range flag.
//   cfg_we/cfg_wdata write active_size; write it only while the block idles.
// timing:
//   one request is worked on at a time; the bitmap lives in a one-port-read,
//   one-port-write word memory and the search reads one word per cycle.
//   an in-range request reads its home word, then scans words below it and
//   then words above it as needed; an out-of-range request goes straight
//   to the result stage. the scan stops at the first hit.
// reset:
//   after arst_n the block sweeps the memory to zero, one word per cycle,
//   with req.ready low; active_size returns to NUM_POSITIONS.
// stall:
//   the response sits in an output register; a new request is taken while
//   it waits, and the next response waits for that register to drain.
module bitmap_nearest_set_search #(
	parameter int NUM_POSITIONS = 1024,
	parameter int WORD_BITS     = 64,
	localparam int POS_W        = $clog2(NUM_POSITIONS),
	localparam int SIZE_W       = POS_W + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	bns_req_if.sink           req,
	bns_rsp_if.source         rsp
);
	import bns_pkg::*;

	localparam int NUM_WORDS = (NUM_POSITIONS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int OFF_W     = $clog2(WORD_BITS);

	// controller states
	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,  // zero sweep after reset
		S_IDLE  = 6'b000010,  // wait for a request
		S_HOME  = 6'b000100,  // home word read back: update and local search
		S_LEFT  = 6'b001000,  // downward word scan
		S_RIGHT = 6'b010000,  // upward word scan
		S_DONE  = 6'b100000   // hand result to output register
	} state_t;

	state_t            st_q, nxt_st;
	logic [SIZE_W-1:0] active_size_q;
	logic [AW-1:0]     clr_q;

	// request context
	logic [POS_W-1:0]  pos_q;
	logic [1:0]        act_q;
	logic [AW-1:0]     lastw_q;
	logic [OFF_W-1:0]  lim_q;
	logic [AW-1:0]     scan_w_q;   // word address whose data is on rdata
	logic              rneed_q;

	// result being built
	logic              bit_q, lf_q, rf_q, oor_q;
	logic [POS_W-1:0]  lp_q, rp_q;

	// output register
	logic              out_vld_q;
	logic              o_bit_q, o_lf_q, o_rf_q, o_oor_q;
	logic [POS_W-1:0]  o_lp_q, o_rp_q;

	// request decode
	logic              accept;
	logic [SIZE_W-1:0] eff_size;
	logic [SIZE_W-1:0] size_m1;
	logic              req_oor;

	// memory and scan
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [AW-1:0]     rd_addr;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] bit_mask;
	logic [WORD_BITS-1:0] new_word;
	logic [AW-1:0]     home_w;
	logic [OFF_W-1:0]  home_off;
	scan_ctrl_t        l_ctrl, r_ctrl;
	logic [WORD_BITS-1:0] scan_word;
	logic              l_found, r_found;
	logic [OFF_W-1:0]  l_idx, r_idx;
	logic              out_go;

	assign home_w   = AW'(pos_q >> OFF_W);
	assign home_off = pos_q[OFF_W-1:0];

	// effective size is clipped to the bitmap
	assign eff_size = (active_size_q > SIZE_W'(NUM_POSITIONS)) ?
		SIZE_W'(NUM_POSITIONS) : active_size_q;
	assign size_m1  = eff_size - SIZE_W'(1);
	assign req_oor  = ({1'b0, req.position} >= eff_size);

	assign req.ready = (st_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	// read-modify-write of the home word
	assign bit_mask = WORD_BITS'(1) << home_off;
	always_comb begin
		unique case (act_q)
			ACT_SET:   new_word = rdata | bit_mask;
			ACT_CLEAR: new_word = rdata & ~bit_mask;
			default:   new_word = rdata;
		endcase
	end

	// writes: zero sweep after reset, write-back of the home word
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = home_w;
		mem_wdata = new_word;
		if (st_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (st_q == S_HOME) begin
			mem_we = (act_q == ACT_SET) || (act_q == ACT_CLEAR);
		end
	end

	bns_mem #(
		.DEPTH (NUM_WORDS),
		.WIDTH (WORD_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// the home word is searched after its update; scanned words as read
	assign scan_word = (st_q == S_HOME) ? new_word : rdata;

	always_comb begin
		l_ctrl         = '0;
		l_ctrl.up      = 1'b0;
		l_ctrl.at_home = (st_q == S_HOME);
		l_ctrl.off     = MAX_OFF_W'(home_off);
		r_ctrl         = '0;
		r_ctrl.up      = 1'b1;
		r_ctrl.at_home = (st_q == S_HOME);
		r_ctrl.off     = MAX_OFF_W'(home_off);
		r_ctrl.lim_en  = (scan_w_q == lastw_q);
		r_ctrl.lim     = MAX_OFF_W'(lim_q);
	end

	bns_word_scan #(.WORD_BITS (WORD_BITS)) u_scan_left (
		.word  (scan_word),
		.ctrl  (l_ctrl),
		.found (l_found),
		.idx   (l_idx)
	);

	bns_word_scan #(.WORD_BITS (WORD_BITS)) u_scan_right (
		.word  (scan_word),
		.ctrl  (r_ctrl),
		.found (r_found),
		.idx   (r_idx)
	);

	assign out_go = !out_vld_q || rsp.ready;

	// sequencing and read address; one word is read per cycle while scanning
	always_comb begin
		nxt_st  = st_q;
		rd_addr = scan_w_q;
		unique case (st_q)
			S_CLEAR: begin
				if (clr_q == AW'(NUM_WORDS - 1)) begin
					nxt_st = S_IDLE;
				end
			end
			S_IDLE: begin
				rd_addr = AW'(req.position >> OFF_W);
				if (accept) begin
					nxt_st = req_oor ? S_DONE : S_HOME;
				end
			end
			S_HOME: begin
				priority if (!l_found && (home_w != '0)) begin
					nxt_st  = S_LEFT;
					rd_addr = home_w - AW'(1);
				end else if (!r_found && (home_w != lastw_q)) begin
					nxt_st  = S_RIGHT;
					rd_addr = home_w + AW'(1);
				end else begin
					nxt_st = S_DONE;
				end
			end
			S_LEFT: begin
				priority if (!l_found && (scan_w_q != '0)) begin
					rd_addr = scan_w_q - AW'(1);
				end else if (rneed_q) begin
					nxt_st  = S_RIGHT;
					rd_addr = home_w + AW'(1);
				end else begin
					nxt_st = S_DONE;
				end
			end
			S_RIGHT: begin
				if (r_found || (scan_w_q == lastw_q)) begin
					nxt_st = S_DONE;
				end else begin
					rd_addr = scan_w_q + AW'(1);
				end
			end
			S_DONE: begin
				if (out_go) begin
					nxt_st = S_IDLE;
				end
			end
			default: nxt_st = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= S_CLEAR;
			clr_q         <= '0;
			active_size_q <= SIZE_W'(NUM_POSITIONS);
			out_vld_q     <= 1'b0;
		end else begin
			st_q <= nxt_st;
			if (st_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_we) begin
				active_size_q <= cfg_wdata;
			end
			if ((st_q == S_DONE) && out_go) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// request context and result datapath
	always_ff @(posedge clk) begin
		scan_w_q <= rd_addr;
		unique case (st_q)
			S_IDLE: begin
				if (accept) begin
					pos_q   <= req.position;
					act_q   <= req.action;
					lastw_q <= AW'(size_m1 >> OFF_W);
					lim_q   <= size_m1[OFF_W-1:0];
					oor_q   <= req_oor;
					bit_q   <= 1'b0;
					lf_q    <= 1'b0;
					lp_q    <= '0;
					rf_q    <= 1'b0;
					rp_q    <= '0;
				end
			end
			S_HOME: begin
				bit_q   <= new_word[home_off];
				rneed_q <= !r_found && (home_w != lastw_q);
				if (l_found) begin
					lf_q <= 1'b1;
					lp_q <= POS_W'({scan_w_q, l_idx});
				end
				if (r_found) begin
					rf_q <= 1'b1;
					rp_q <= POS_W'({scan_w_q, r_idx});
				end
			end
			S_LEFT: begin
				if (l_found) begin
					lf_q <= 1'b1;
					lp_q <= POS_W'({scan_w_q, l_idx});
				end
			end
			S_RIGHT: begin
				if (r_found) begin
					rf_q <= 1'b1;
					rp_q <= POS_W'({scan_w_q, r_idx});
				end
			end
			S_DONE: begin
				if (out_go) begin
					o_bit_q <= bit_q;
					o_lf_q  <= lf_q;
					o_lp_q  <= lp_q;
					o_rf_q  <= rf_q;
					o_rp_q  <= rp_q;
					o_oor_q <= oor_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.bit_is_set     = o_bit_q;
	assign rsp.left_found     = o_lf_q;
	assign rsp.left_position  = o_lp_q;
	assign rsp.right_hit      = o_rf_q;
	assign rsp.right_position = o_rp_q;
	assign rsp.out_of_range   = o_oor_q;

endmodule

// File: verif/bns_search_checker.sv
`timescale 1ns / 1ps
// response checker for bitmap_nearest_set_search: mirrors bitmap and active size
// depends on bns_pkg, bns_req_if, bns_rsp_if
module bns_search_checker #(
	parameter int NUM_POSITIONS = 1024,
	localparam int POS_W        = $clog2(NUM_POSITIONS),
	localparam int SIZE_W       = POS_W + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	bns_req_if                req,
	bns_rsp_if                rsp,
	output int                mismatch_count,
	output int                searches_outstanding
);
	import bns_pkg::*;

	typedef struct packed {
		logic             bit_is_set;
		logic             left_found;
		logic [POS_W-1:0] left_position;
		logic             right_hit;
		logic [POS_W-1:0] right_position;
		logic             out_of_range;
	} search_result_t;

	logic [NUM_POSITIONS-1:0] mirror_bits;
	logic [SIZE_W-1:0]        mirror_size;
	search_result_t           pending_searches[$];
	int                       failures = 0;

	// bit state plus nearest set bit on each side, right side bounded by limit
	function automatic search_result_t nearest_set_around(
		input logic [NUM_POSITIONS-1:0] bits,
		input int                       pos,
		input int                       limit
	);
		search_result_t res;
		int             p;
		res = '0;
		res.bit_is_set = bits[pos];
		for (p = pos - 1; p >= 0; p--) begin
			if (bits[p]) begin
				res.left_found    = 1'b1;
				res.left_position = p[POS_W-1:0];
				break;
			end
		end
		for (p = pos + 1; p < limit; p++) begin
			if (bits[p]) begin
				res.right_hit      = 1'b1;
				res.right_position = p[POS_W-1:0];
				break;
			end
		end
		return res;
	endfunction

	function automatic string show(input search_result_t r);
		return $sformatf("set=%0b left=%0b/%0d right=%0b/%0d oor=%0b", r.bit_is_set,
			r.left_found, r.left_position, r.right_hit, r.right_position, r.out_of_range);
	endfunction

	always @(posedge clk or negedge arst_n) begin : check_step
		search_result_t want;
		search_result_t got;
		int             limit;
		int             pos;
		if (!arst_n) begin
			mirror_bits = '0;
			mirror_size = SIZE_W'(NUM_POSITIONS);
			pending_searches.delete();
			searches_outstanding <= 0;
		end else begin
			if (cfg_we)
				mirror_size = cfg_wdata;

			// response side first: it always belongs to an older request
			if (rsp.valid && rsp.ready) begin
				got.bit_is_set     = rsp.bit_is_set;
				got.left_found     = rsp.left_found;
				got.left_position  = rsp.left_position;
				got.right_hit      = rsp.right_hit;
				got.right_position = rsp.right_position;
				got.out_of_range   = rsp.out_of_range;
				if (pending_searches.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("response with no request outstanding: %s", show(got));
				end else begin
					want = pending_searches.pop_front();
					if (got !== want) begin
						failures++;
						if (failures <= 10)
							$display("mismatch: expected %s, got %s", show(want), show(got));
					end
				end
			end

			if (req.valid && req.ready) begin
				pos   = int'(req.position);
				limit = (int'(mirror_size) > NUM_POSITIONS) ? NUM_POSITIONS : int'(mirror_size);
				if (pos >= limit) begin
					want = '0;
					want.out_of_range = 1'b1;
				end else begin
					case (req.action)
						ACT_SET:   mirror_bits[pos] = 1'b1;
						ACT_CLEAR: mirror_bits[pos] = 1'b0;
						default:   ;
					endcase
					want = nearest_set_around(mirror_bits, pos, limit);
				end
				pending_searches.push_back(want);
			end

			searches_outstanding <= pending_searches.size();
		end
	end

	assign mismatch_count = failures;

endmodule

// File: verif/tb_bitmap_nearest_set_search.sv
`timescale 1ns / 1ps
// testbench top for bitmap_nearest_set_search: drives requests, responses and config
// depends on bns_pkg, bns_req_if, bns_rsp_if, bns_search_checker and the block
module tb_bitmap_nearest_set_search;
	import bns_pkg::*;

	localparam int NUM_POSITIONS = 1024;
	localparam int POS_W         = $clog2(NUM_POSITIONS);
	localparam int SIZE_W        = POS_W + 1;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int RANDOM_PHASES = 12;
	localparam int LONG_HOLD     = 400;
	// action code the block treats like a query
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// bias of the random actions within a phase
	typedef enum int {MIX_EVEN, MIX_FILL, MIX_DRAIN} action_mix_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;
	int                mismatch_count;
	int                searches_outstanding;
	int                cycle_count = 0;
	bit                steady = 1'b0;     // no idling on either side
	bit                hold_long = 1'b0;  // ask the receiver for one long stall

	bns_req_if #(.POS_W(POS_W)) req_ch ();
	bns_rsp_if #(.POS_W(POS_W)) rsp_ch ();

	bitmap_nearest_set_search #(
		.NUM_POSITIONS(NUM_POSITIONS),
		.WORD_BITS    (64)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	bns_search_checker #(.NUM_POSITIONS(NUM_POSITIONS)) u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.req                 (req_ch),
		.rsp                 (rsp_ch),
		.mismatch_count      (mismatch_count),
		.searches_outstanding(searches_outstanding)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hard stop in case a handshake never completes
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_bitmap_nearest_set_search NOT OK");
			$finish;
		end
	end

	// idle cycles before the next request or response, none in steady stretches
	function automatic int draw_gap();
		return steady ? 0 : int'($urandom_range(0, 11));
	endfunction

	function automatic logic [1:0] draw_action(input action_mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:  return (r < 60) ? ACT_SET : (r < 75) ? ACT_CLEAR :
				(r < 95) ? ACT_QUERY : ACT_UNUSED;
			MIX_DRAIN: return (r < 15) ? ACT_SET : (r < 70) ? ACT_CLEAR :
				(r < 95) ? ACT_QUERY : ACT_UNUSED;
			default:   return (r < 30) ? ACT_SET : (r < 60) ? ACT_CLEAR :
				(r < 95) ? ACT_QUERY : ACT_UNUSED;
		endcase
	endfunction

	// offer one request and hold it until the block takes it
	task automatic send_search(input logic [1:0] act, input logic [POS_W-1:0] pos);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.action   <= act;
		req_ch.position <= pos;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// drop valid, let every response drain, then write active_size
	task automatic set_active_size(input logic [SIZE_W-1:0] size);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (searches_outstanding != 0)
			@(posedge clk);
		// spare cycles so the block is surely back at rest
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= size;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// response side: random stalls per response, one long hold-off on request
	initial begin : receiver
		int gap;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				hold_long = 1'b0;
				gap = LONG_HOLD;
			end else begin
				gap = draw_gap();
			end
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid)
				@(posedge clk);
		end
	end

	initial begin : stimulus
		int               ph;
		int               n;
		int               size;
		int               span;
		action_mix_t      mix;
		logic [POS_W-1:0] pos;

		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= '0;
		req_ch.valid    <= 1'b0;
		req_ch.action   <= ACT_QUERY;
		req_ch.position <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: full size after reset, empty map first
		send_search(ACT_QUERY, 10'd0);
		send_search(ACT_SET, 10'd0);
		send_search(ACT_SET, 10'd1023);
		send_search(ACT_QUERY, 10'd512);
		// neighbors across a word boundary
		send_search(ACT_SET, 10'd63);
		send_search(ACT_SET, 10'd64);
		send_search(ACT_QUERY, 10'd63);
		send_search(ACT_QUERY, 10'd64);
		send_search(ACT_UNUSED, 10'd5);
		send_search(ACT_CLEAR, 10'd0);
		send_search(ACT_QUERY, 10'd0);
		// clearing a bit that is already clear
		send_search(ACT_CLEAR, 10'd1000);
		send_search(ACT_SET, 10'd1022);
		send_search(ACT_QUERY, 10'd1023);

		// smallest active size: only position 0 is in range
		set_active_size(11'd1);
		send_search(ACT_SET, 10'd0);
		send_search(ACT_QUERY, 10'd1);
		send_search(ACT_CLEAR, 10'd1023);

		// zero size rejects everything, the map must stay untouched
		set_active_size(11'd0);
		send_search(ACT_SET, 10'd0);
		send_search(ACT_QUERY, 10'd1023);

		// size beyond the bitmap behaves as the full bitmap
		set_active_size(11'd2047);
		send_search(ACT_QUERY, 10'd1023);
		send_search(ACT_CLEAR, 10'd1022);

		// bits kept above a lowered size must not show up on the right
		set_active_size(11'd100);
		send_search(ACT_QUERY, 10'd50);
		send_search(ACT_QUERY, 10'd99);
		send_search(ACT_SET, 10'd99);

		// random phases with a size, an action bias and an idling style each
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0:       size = 1024;
				1:       size = 64;
				2:       size = 1024;
				3:       size = 65;
				4:       size = 2047;
				5:       size = 2;
				6:       size = 700;
				7:       size = 1025;
				8:       size = 128;
				9:       size = 1024;
				10:      size = 513;
				default: size = $urandom_range(1, 2047);
			endcase
			set_active_size(SIZE_W'(size));
			span   = (size > NUM_POSITIONS) ? NUM_POSITIONS : size;
			steady = ($urandom_range(0, 3) == 0);
			// fill early, drain later so scans cross many empty words
			case (ph % 3)
				0:       mix = MIX_FILL;
				1:       mix = MIX_EVEN;
				default: mix = MIX_DRAIN;
			endcase
			// back up the block once while the sender keeps offering
			if (ph == 2)
				hold_long = 1'b1;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 9) == 0)
					pos = POS_W'($urandom_range(0, NUM_POSITIONS - 1));
				else
					pos = POS_W'($urandom_range(0, span - 1));
				send_search(draw_action(mix), pos);
			end
		end
		steady = 1'b0;

		// drain, then wait on for anything stray
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (searches_outstanding != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);

		if (mismatch_count == 0 && searches_outstanding == 0)
			$display("tb_bitmap_nearest_set_search OK");
		else
			$display("tb_bitmap_nearest_set_search NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
hdl/bns_pkg.sv
hdl/bns_req_if.sv
hdl/bns_rsp_if.sv
hdl/bns_mem.sv
hdl/bns_word_scan.sv
hdl/bitmap_nearest_set_search.sv
verif/bns_search_checker.sv
verif/tb_bitmap_nearest_set_search.sv
